FILE: hw/rtl/a2rm_pkg.sv
// ----------------------------------------------------------------------------
// a2rm_pkg
// Shared types, fixed-point constants and the arctangent table for the
// rotation vector to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package a2rm_pkg;

    // default field widths
    localparam int IN_WIDTH_DEFAULT  = 16;
    localparam int OUT_WIDTH_DEFAULT = 16;

    // small-angle limit register
    localparam int                     LIMIT_WIDTH = 15;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd1;

    // internal Q30 datapath
    localparam int FRAC_BITS    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 31;
    localparam int QUOT_WIDTH   = 31;
    localparam int THETA_WIDTH  = 33;
    localparam int CW           = 36;

    typedef logic signed [CW-1:0] cordic_t;

    localparam cordic_t ONE_Q30     = 36'sd1073741824;
    localparam cordic_t PI_Q30      = 36'sd3373259426;
    localparam cordic_t HALF_PI_Q30 = 36'sd1686629713;
    localparam cordic_t TWO_PI_Q30  = 36'sd6746518852;
    localparam cordic_t GAIN_Q30    = 36'sd652032874;

    // control bits that travel with every item
    typedef struct packed {
        logic valid;
        logic small_ang;
        logic neg;
    } ctl_t;

    // rotation angle of one cordic iteration, Q30
    function automatic cordic_t atan_q30(input int step);
        cordic_t a;
        case (step)
            0:       a = 36'sd843314857;
            1:       a = 36'sd497837829;
            2:       a = 36'sd263043837;
            3:       a = 36'sd133525159;
            4:       a = 36'sd67021687;
            5:       a = 36'sd33543516;
            6:       a = 36'sd16775851;
            7:       a = 36'sd8388437;
            8:       a = 36'sd4194283;
            9:       a = 36'sd2097149;
            default: a = cordic_t'(36'sd1 <<< (FRAC_BITS - step));
        endcase
        return a;
    endfunction

endpackage

FILE: hw/rtl/a2rm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// a2rm_sqrt_cell
// One cell of the square root chain: decides one bit of the integer root
// and hands the remainder, partial root and vector to the next cell.
// ----------------------------------------------------------------------------
module a2rm_sqrt_cell #(
    parameter int IN_WIDTH = a2rm_pkg::IN_WIDTH_DEFAULT,
    parameter int BIT      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  a2rm_pkg::ctl_t        ctl_in,
    input  logic [2*IN_WIDTH-1:0] rem_in,
    input  logic [IN_WIDTH-1:0]   root_in,
    input  logic [3*IN_WIDTH-1:0] vec_in,
    output a2rm_pkg::ctl_t        ctl_out,
    output logic [2*IN_WIDTH-1:0] rem_out,
    output logic [IN_WIDTH-1:0]   root_out,
    output logic [3*IN_WIDTH-1:0] vec_out
);
    import a2rm_pkg::*;

    localparam int RW = 2 * IN_WIDTH;
    localparam int TW = RW + 1;

    logic [TW-1:0]         trial;
    logic                  fits;
    ctl_t                  ctl_reg;
    logic [RW-1:0]         rem_reg;
    logic [RW-1:0]         rem_next;
    logic [IN_WIDTH-1:0]   root_reg;
    logic [IN_WIDTH-1:0]   root_next;
    logic [3*IN_WIDTH-1:0] vec_reg;

    // trial value (2 * root + bit) * bit weight
    assign trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign fits  = {1'b0, rem_in} >= trial;

    always_comb begin
        rem_next  = fits ? rem_in - trial[RW-1:0] : rem_in;
        root_next = fits ? (root_in | (IN_WIDTH'(1) << BIT)) : root_in;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            vec_reg  <= vec_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign vec_out  = vec_reg;

endmodule

FILE: hw/rtl/a2rm_step_cell.sv
// ----------------------------------------------------------------------------
// a2rm_step_cell
// One cell of the axis/angle chain: one quotient bit for each of the three
// axis components and, for STEP below CORDIC_STEPS, one cordic rotation of the angle.
// ----------------------------------------------------------------------------
module a2rm_step_cell #(
    parameter int IN_WIDTH = a2rm_pkg::IN_WIDTH_DEFAULT,
    parameter int STEP     = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  a2rm_pkg::ctl_t                        ctl_in,
    input  logic [IN_WIDTH-1:0]                   norm_in,
    input  logic [2:0][IN_WIDTH:0]                rem_in,
    input  logic [2:0][a2rm_pkg::QUOT_WIDTH-1:0]  quot_in,
    input  a2rm_pkg::cordic_t                     x_in,
    input  a2rm_pkg::cordic_t                     y_in,
    input  a2rm_pkg::cordic_t                     z_in,
    input  logic [3*IN_WIDTH-1:0]                 vec_in,
    output a2rm_pkg::ctl_t                        ctl_out,
    output logic [IN_WIDTH-1:0]                   norm_out,
    output logic [2:0][IN_WIDTH:0]                rem_out,
    output logic [2:0][a2rm_pkg::QUOT_WIDTH-1:0]  quot_out,
    output a2rm_pkg::cordic_t                     x_out,
    output a2rm_pkg::cordic_t                     y_out,
    output a2rm_pkg::cordic_t                     z_out,
    output logic [3*IN_WIDTH-1:0]                 vec_out
);
    import a2rm_pkg::*;

    localparam int      RW     = IN_WIDTH + 1;
    localparam bit      ROTATE = (STEP < CORDIC_STEPS);
    localparam cordic_t ANGLE  = ROTATE ? atan_q30(STEP) : '0;

    logic [2:0][RW-1:0]         shifted;
    logic [2:0]                 ge;
    logic [2:0][RW-1:0]         rem_next;
    logic [2:0][QUOT_WIDTH-1:0] quot_next;
    cordic_t                    dx;
    cordic_t                    dy;
    cordic_t                    x_next;
    cordic_t                    y_next;
    cordic_t                    z_next;

    ctl_t                       ctl_reg;
    logic [IN_WIDTH-1:0]        norm_reg;
    logic [2:0][RW-1:0]         rem_reg;
    logic [2:0][QUOT_WIDTH-1:0] quot_reg;
    cordic_t                    x_reg;
    cordic_t                    y_reg;
    cordic_t                    z_reg;
    logic [3*IN_WIDTH-1:0]      vec_reg;

    // restoring division, one quotient bit per lane
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            shifted[k]   = (STEP == 0) ? rem_in[k] : {rem_in[k][RW-2:0], 1'b0};
            ge[k]        = shifted[k] >= RW'(norm_in);
            rem_next[k]  = ge[k] ? shifted[k] - RW'(norm_in) : shifted[k];
            quot_next[k] = {quot_in[k][QUOT_WIDTH-2:0], ge[k]};
        end
    end

    // cordic rotation toward zero residual angle
    always_comb begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!ROTATE) begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end else if (!z_in[CW-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            norm_reg <= norm_in;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            vec_reg  <= vec_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign norm_out = norm_reg;
    assign rem_out  = rem_reg;
    assign quot_out = quot_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign vec_out  = vec_reg;

endmodule

FILE: hw/rtl/a2rm_matrix.sv
// ----------------------------------------------------------------------------
// a2rm_matrix
// Five-stage tail: signed axis and sin/cos, (1-cos)K products, the A matrix,
// the A*K products, then rounding, identity, saturation and the small-angle
// first-order result.
// ----------------------------------------------------------------------------
module a2rm_matrix #(
    parameter int IN_WIDTH  = a2rm_pkg::IN_WIDTH_DEFAULT,
    parameter int OUT_WIDTH = a2rm_pkg::OUT_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  a2rm_pkg::ctl_t                        ctl_in,
    input  logic [2:0][a2rm_pkg::QUOT_WIDTH-1:0]  quot_in,
    input  a2rm_pkg::cordic_t                     x_in,
    input  a2rm_pkg::cordic_t                     y_in,
    input  logic [3*IN_WIDTH-1:0]                 vec_in,
    output a2rm_pkg::ctl_t                        ctl_out,
    output logic [8:0][OUT_WIDTH-1:0]             ent_out
);
    import a2rm_pkg::*;

    localparam int UW       = 32;
    localparam int PW       = 64;
    localparam int EW       = PW + 1;
    localparam int AW       = 34;
    localparam int MW       = 66;
    localparam int ACC_W    = 68;
    localparam int OUT_FRAC = OUT_WIDTH - 2;
    localparam int IN_FRAC  = IN_WIDTH - 3;
    localparam int SH       = 2 * FRAC_BITS - OUT_FRAC;
    localparam int D        = OUT_FRAC - IN_FRAC;
    localparam int DL       = (D >= 0) ? D : 0;
    localparam int DR       = (D < 0) ? -D : 0;
    localparam int DRM1     = (DR > 0) ? DR - 1 : 0;

    localparam logic signed [EW-1:0]    HALF_Q30 = EW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_OUT = ACC_W'(1) <<< (SH - 1);
    localparam logic signed [ACC_W-1:0] ONE_ACC  = ACC_W'(1) <<< OUT_FRAC;
    localparam logic signed [ACC_W-1:0] HALF_IN  = (DR > 0) ? (ACC_W'(1) <<< DRM1) : '0;

    // clamp to [-1, +1] in the output format
    function automatic logic [OUT_WIDTH-1:0] sat(input logic signed [ACC_W-1:0] val);
        logic signed [ACC_W-1:0] res;
        if (val > ONE_ACC) begin
            res = ONE_ACC;
        end else if (val < -ONE_ACC) begin
            res = -ONE_ACC;
        end else begin
            res = val;
        end
        return res[OUT_WIDTH-1:0];
    endfunction

    // input component moved to the output format, half-up when bits drop
    function automatic logic signed [ACC_W-1:0] rescale(input logic [IN_WIDTH-1:0] raw);
        logic signed [ACC_W-1:0] ext;
        ext = ACC_W'($signed(raw));
        return ((ext <<< DL) + HALF_IN) >>> DR;
    endfunction

    // stage 1: signed axis, sin and 1 - cos
    ctl_t                  ctl1_reg;
    cordic_t               s1_reg;
    cordic_t               omc1_reg;
    logic signed [UW-1:0]  u1_reg [3];
    logic [3*IN_WIDTH-1:0] vec1_reg;
    cordic_t               s1_next;
    cordic_t               omc1_next;
    logic signed [UW-1:0]  u1_next [3];

    // stage 2: (1 - cos) * u products
    ctl_t                  ctl2_reg;
    cordic_t               s2_reg;
    logic signed [PW-1:0]  p2_reg [3];
    logic signed [UW-1:0]  u2_reg [3];
    logic [3*IN_WIDTH-1:0] vec2_reg;
    logic signed [PW-1:0]  p2_next [3];

    // stage 3: A and K matrices
    ctl_t                  ctl3_reg;
    logic signed [AW-1:0]  a3_reg [3][3];
    logic signed [UW-1:0]  k3_reg [3][3];
    logic [3*IN_WIDTH-1:0] vec3_reg;
    logic signed [AW-1:0]  ap [3];
    logic signed [AW-1:0]  an [3];
    logic signed [AW-1:0]  a3_next [3][3];
    logic signed [UW-1:0]  k3_next [3][3];

    // stage 4: A * K products
    ctl_t                  ctl4_reg;
    logic signed [MW-1:0]  m4_reg [3][3][3];
    logic [3*IN_WIDTH-1:0] vec4_reg;
    logic signed [MW-1:0]  m4_next [3][3][3];

    // stage 5: result entries
    ctl_t                     ctl5_reg;
    logic [8:0][OUT_WIDTH-1:0] ent5_reg;
    logic signed [ACC_W-1:0]  acc [3][3];
    logic signed [ACC_W-1:0]  rnd [3][3];
    logic signed [ACC_W-1:0]  sx;
    logic signed [ACC_W-1:0]  sy;
    logic signed [ACC_W-1:0]  sz;
    logic [8:0][OUT_WIDTH-1:0] ent_full;
    logic [8:0][OUT_WIDTH-1:0] ent_small;
    logic [8:0][OUT_WIDTH-1:0] ent5_next;

    // stage 1 logic
    always_comb begin
        s1_next   = ctl_in.neg ? -y_in : y_in;
        omc1_next = ONE_Q30 - (ctl_in.neg ? -x_in : x_in);
        for (int k = 0; k < 3; k++) begin
            u1_next[k] = vec_in[k*IN_WIDTH + IN_WIDTH - 1] ? -UW'(quot_in[k])
                                                            : UW'(quot_in[k]);
        end
    end

    // stage 2 logic
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p2_next[k] = PW'(omc1_reg) * PW'(u1_reg[k]);
        end
    end

    // stage 3 logic: round both signs of each product half up
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ap[k] = AW'((EW'(p2_reg[k]) + HALF_Q30) >>> FRAC_BITS);
            an[k] = AW'((-EW'(p2_reg[k]) + HALF_Q30) >>> FRAC_BITS);
        end
        a3_next[0][0] = AW'(s2_reg); a3_next[0][1] = an[2];         a3_next[0][2] = ap[1];
        a3_next[1][0] = ap[2];       a3_next[1][1] = AW'(s2_reg);   a3_next[1][2] = an[0];
        a3_next[2][0] = an[1];       a3_next[2][1] = ap[0];         a3_next[2][2] = AW'(s2_reg);
        k3_next[0][0] = '0;          k3_next[0][1] = -u2_reg[2];    k3_next[0][2] = u2_reg[1];
        k3_next[1][0] = u2_reg[2];   k3_next[1][1] = '0;            k3_next[1][2] = -u2_reg[0];
        k3_next[2][0] = -u2_reg[1];  k3_next[2][1] = u2_reg[0];     k3_next[2][2] = '0;
    end

    // stage 4 logic: zero diagonal of K drops one term per entry
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    if (k == j) begin
                        m4_next[i][j][k] = '0;
                    end else begin
                        m4_next[i][j][k] = MW'(a3_reg[i][k]) * MW'(k3_reg[k][j]);
                    end
                end
            end
        end
    end

    // stage 5 logic: full result and first-order result
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc[i][j] = ACC_W'(m4_reg[i][j][0]) + ACC_W'(m4_reg[i][j][1])
                          + ACC_W'(m4_reg[i][j][2]);
                rnd[i][j] = (acc[i][j] + HALF_OUT) >>> SH;
                ent_full[i*3+j] = sat(rnd[i][j] + ((i == j) ? ONE_ACC : '0));
            end
        end
        sx = rescale(vec4_reg[0*IN_WIDTH +: IN_WIDTH]);
        sy = rescale(vec4_reg[1*IN_WIDTH +: IN_WIDTH]);
        sz = rescale(vec4_reg[2*IN_WIDTH +: IN_WIDTH]);
        ent_small[0] = sat(ONE_ACC);
        ent_small[1] = sat(-sz);
        ent_small[2] = sat(sy);
        ent_small[3] = sat(sz);
        ent_small[4] = sat(ONE_ACC);
        ent_small[5] = sat(-sx);
        ent_small[6] = sat(-sy);
        ent_small[7] = sat(sx);
        ent_small[8] = sat(ONE_ACC);
        ent5_next = ctl4_reg.small_ang ? ent_small : ent_full;
    end

    // control through the five stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    // payload through the five stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg   <= s1_next;
            omc1_reg <= omc1_next;
            u1_reg   <= u1_next;
            vec1_reg <= vec_in;
            s2_reg   <= s1_reg;
            p2_reg   <= p2_next;
            u2_reg   <= u1_reg;
            vec2_reg <= vec1_reg;
            a3_reg   <= a3_next;
            k3_reg   <= k3_next;
            vec3_reg <= vec2_reg;
            m4_reg   <= m4_next;
            vec4_reg <= vec3_reg;
            ent5_reg <= ent5_next;
        end
    end

    assign ctl_out = ctl5_reg;
    assign ent_out = ent5_reg;

endmodule

FILE: hw/rtl/axis_angle_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// Throughput: one rotation vector per cycle while the skid register is empty
// (s_tready is low while it holds a result); the pipeline is a chain of
// IN_WIDTH square root cells, 31 divide/cordic cells and five matrix stages.
// Reset (aresetn low, synchronous) empties the pipeline and output buffer and
// sets small_angle_limit to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix #(
    parameter int IN_WIDTH  = a2rm_pkg::IN_WIDTH_DEFAULT,
    parameter int OUT_WIDTH = a2rm_pkg::OUT_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: small_angle_limit
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [a2rm_pkg::LIMIT_WIDTH-1:0] cfg_data,
    // input: vec_x, vec_y, vec_z from the lowest bit up
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((3*IN_WIDTH+7)/8)*8-1:0]  s_tdata,
    // output: r00, r01, r02, r10, r11, r12, r20, r21, r22 from the lowest bit up
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((9*OUT_WIDTH+7)/8)*8-1:0] m_tdata,
    // output: small_angle_used
    output logic                             m_tuser
);
    import a2rm_pkg::*;

    localparam int M_TDATA_W = ((9*OUT_WIDTH+7)/8)*8;
    localparam int RW        = 2 * IN_WIDTH;
    localparam int PAY_W     = 9 * OUT_WIDTH + 1;

    logic adv;

    // configuration register
    logic [LIMIT_WIDTH-1:0] limit_reg;

    // input and square stages
    ctl_t                  ctl0_reg;
    logic [3*IN_WIDTH-1:0] vec0_reg;
    ctl_t                  ctl1_reg;
    logic [3*IN_WIDTH-1:0] vec1_reg;
    logic [RW-1:0]         sq1_reg [3];
    logic [RW-1:0]         sq1_next [3];
    logic [RW-1:0]         sumsq;

    // square root chain
    ctl_t                  sr_ctl  [0:IN_WIDTH];
    logic [RW-1:0]         sr_rem  [0:IN_WIDTH];
    logic [IN_WIDTH-1:0]   sr_root [0:IN_WIDTH];
    logic [3*IN_WIDTH-1:0] sr_vec  [0:IN_WIDTH];

    // angle reduction stage
    logic [IN_WIDTH-1:0]          norm;
    logic [THETA_WIDTH-1:0]       theta;
    cordic_t                      ang0;
    cordic_t                      ang1;
    cordic_t                      ang2;
    ctl_t                         red_ctl_next;
    logic [2:0][IN_WIDTH:0]       mag;
    ctl_t                         red_ctl_reg;
    logic [IN_WIDTH-1:0]          red_norm_reg;
    logic [2:0][IN_WIDTH:0]       red_mag_reg;
    cordic_t                      red_z_reg;
    logic [3*IN_WIDTH-1:0]        red_vec_reg;

    // divide / cordic chain
    ctl_t                         st_ctl  [0:DIV_STEPS];
    logic [IN_WIDTH-1:0]          st_norm [0:DIV_STEPS];
    logic [2:0][IN_WIDTH:0]       st_rem  [0:DIV_STEPS];
    logic [2:0][QUOT_WIDTH-1:0]   st_quot [0:DIV_STEPS];
    cordic_t                      st_x    [0:DIV_STEPS];
    cordic_t                      st_y    [0:DIV_STEPS];
    cordic_t                      st_z    [0:DIV_STEPS];
    logic [3*IN_WIDTH-1:0]        st_vec  [0:DIV_STEPS];

    // matrix tail and output buffer
    ctl_t                         mx_ctl;
    logic [8:0][OUT_WIDTH-1:0]    mx_ent;
    logic                         push;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [PAY_W-1:0]             out_data_reg;
    logic [PAY_W-1:0]             out_data_next;
    logic                         skid_valid_reg;
    logic                         skid_valid_next;
    logic [PAY_W-1:0]             skid_data_reg;

    // the whole chain moves unless the skid register holds a result
    assign adv       = !skid_valid_reg;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // squares of the components
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq1_next[k] = RW'($signed(vec0_reg[k*IN_WIDTH +: IN_WIDTH])
                            * $signed(vec0_reg[k*IN_WIDTH +: IN_WIDTH]));
        end
        sumsq = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg <= '0;
            ctl1_reg <= '0;
        end else if (adv) begin
            ctl0_reg <= '{valid: s_tvalid, small_ang: 1'b0, neg: 1'b0};
            ctl1_reg <= ctl0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vec0_reg <= s_tdata[3*IN_WIDTH-1:0];
            vec1_reg <= vec0_reg;
            sq1_reg  <= sq1_next;
        end
    end

    // square root chain, most significant root bit first
    assign sr_ctl[0]  = ctl1_reg;
    assign sr_rem[0]  = sumsq;
    assign sr_root[0] = '0;
    assign sr_vec[0]  = vec1_reg;

    for (genvar g = 0; g < IN_WIDTH; g++) begin : g_sqrt
        a2rm_sqrt_cell #(
            .IN_WIDTH (IN_WIDTH),
            .BIT      (IN_WIDTH - 1 - g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .ctl_in   (sr_ctl[g]),
            .rem_in   (sr_rem[g]),
            .root_in  (sr_root[g]),
            .vec_in   (sr_vec[g]),
            .ctl_out  (sr_ctl[g+1]),
            .rem_out  (sr_rem[g+1]),
            .root_out (sr_root[g+1]),
            .vec_out  (sr_vec[g+1])
        );
    end

    // small-angle decision, angle range reduction and axis magnitudes
    always_comb begin
        norm  = sr_root[IN_WIDTH];
        theta = THETA_WIDTH'(norm) << (THETA_WIDTH - IN_WIDTH);
        ang0  = cordic_t'(theta);
        ang1  = (ang0 > PI_Q30) ? ang0 - TWO_PI_Q30 : ang0;
        red_ctl_next           = sr_ctl[IN_WIDTH];
        red_ctl_next.small_ang = (norm == '0) || (32'(norm) < 32'(limit_reg));
        red_ctl_next.neg       = 1'b0;
        if (ang1 > HALF_PI_Q30) begin
            ang2             = ang1 - PI_Q30;
            red_ctl_next.neg = 1'b1;
        end else if (ang1 < -HALF_PI_Q30) begin
            ang2             = ang1 + PI_Q30;
            red_ctl_next.neg = 1'b1;
        end else begin
            ang2 = ang1;
        end
        for (int k = 0; k < 3; k++) begin
            mag[k] = {1'b0, sr_vec[IN_WIDTH][k*IN_WIDTH + IN_WIDTH - 1]
                            ? -sr_vec[IN_WIDTH][k*IN_WIDTH +: IN_WIDTH]
                            : sr_vec[IN_WIDTH][k*IN_WIDTH +: IN_WIDTH]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_ctl_reg <= '0;
        end else if (adv) begin
            red_ctl_reg <= red_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_norm_reg <= norm;
            red_mag_reg  <= mag;
            red_z_reg    <= ang2;
            red_vec_reg  <= sr_vec[IN_WIDTH];
        end
    end

    // divide / cordic chain
    assign st_ctl[0]  = red_ctl_reg;
    assign st_norm[0] = red_norm_reg;
    assign st_rem[0]  = red_mag_reg;
    assign st_quot[0] = '0;
    assign st_x[0]    = GAIN_Q30;
    assign st_y[0]    = '0;
    assign st_z[0]    = red_z_reg;
    assign st_vec[0]  = red_vec_reg;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        a2rm_step_cell #(
            .IN_WIDTH (IN_WIDTH),
            .STEP     (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .ctl_in   (st_ctl[g]),
            .norm_in  (st_norm[g]),
            .rem_in   (st_rem[g]),
            .quot_in  (st_quot[g]),
            .x_in     (st_x[g]),
            .y_in     (st_y[g]),
            .z_in     (st_z[g]),
            .vec_in   (st_vec[g]),
            .ctl_out  (st_ctl[g+1]),
            .norm_out (st_norm[g+1]),
            .rem_out  (st_rem[g+1]),
            .quot_out (st_quot[g+1]),
            .x_out    (st_x[g+1]),
            .y_out    (st_y[g+1]),
            .z_out    (st_z[g+1]),
            .vec_out  (st_vec[g+1])
        );
    end

    // matrix assembly
    a2rm_matrix #(
        .IN_WIDTH  (IN_WIDTH),
        .OUT_WIDTH (OUT_WIDTH)
    ) u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .ctl_in  (st_ctl[DIV_STEPS]),
        .quot_in (st_quot[DIV_STEPS]),
        .x_in    (st_x[DIV_STEPS]),
        .y_in    (st_y[DIV_STEPS]),
        .vec_in  (st_vec[DIV_STEPS]),
        .ctl_out (mx_ctl),
        .ent_out (mx_ent)
    );

    // output register with skid register behind it
    assign push = adv && mx_ctl.valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : {mx_ctl.small_ang, mx_ent};
            skid_valid_next = 1'b0;
        end else if (push) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        if (push && !skid_valid_reg) begin
            skid_data_reg <= {mx_ctl.small_ang, mx_ent};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg[PAY_W-2:0]);
    assign m_tuser  = out_data_reg[PAY_W-1];

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation vector to matrix testbench
// Streams rotation vectors through the converter under bursty input and a
// stalling output, predicts each matrix in fixed point and compares every
// entry and the small-angle flag. The limit register is swept between phases.
// ----------------------------------------------------------------------------
module testbench;
    import a2rm_pkg::*;

    localparam int IW = 16;
    localparam int OW = 16;
    localparam int OFRAC = OW - 2;
    localparam int IFRAC = IW - 3;
    localparam int LATENCY = IW + 39;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 750;

    typedef struct packed {
        logic       small_ang;
        logic [143:0] mat;
    } rot_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [LIMIT_WIDTH-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic m_tuser;

    always #5 aclk = ~aclk;

    axis_angle_to_rotation_matrix #(.IN_WIDTH(IW), .OUT_WIDTH(OW)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    logic [47:0] pending_vecs[$];
    rot_result_t expected_mats[$];
    logic [LIMIT_WIDTH-1:0] angle_limit = LIMIT_RESET;
    int errors = 0;
    int n_matrices = 0;
    int n_small = 0;
    int idle_cycles = 0;
    bit hold_input = 1'b0;
    bit stall_free = 1'b0;

    // floor shift for signed values
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
        longint one;
        one = longint'(1) << OFRAC;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_step(int i);
        case (i)
            0: return 843314857;
            1: return 497837829;
            2: return 263043837;
            3: return 133525159;
            4: return 67021687;
            5: return 33543516;
            6: return 16775851;
            7: return 8388437;
            8: return 4194283;
            9: return 2097149;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    // q30 sine and cosine of a non-negative angle
    task automatic angle_sin_cos(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit neg;
        x = 652032874;
        y = 0;
        neg = 1'b0;
        if (ang > 64'sd3373259426) ang -= 64'sd6746518852;
        if (ang > 64'sd1686629713) begin
            ang -= 64'sd3373259426;
            neg = 1'b1;
        end else if (ang < -64'sd1686629713) begin
            ang += 64'sd3373259426;
            neg = 1'b1;
        end
        z = ang;
        for (int i = 0; i < 30; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    // rodrigues matrix of one rotation vector
    task automatic rotation_of(input logic [47:0] vec, output rot_result_t res);
        longint v[3], u[3], kk[3][3], aa[3][3], rr[3][3];
        longint unsigned mag[3], sumsq;
        longint nrm, s, c, omc, acc, one, q;
        bit is_small;
        one = longint'(1) << OFRAC;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = longint'($signed(vec[16*i +: 16]));
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            sumsq += mag[i] * mag[i];
        end
        nrm = int_sqrt(sumsq);
        is_small = (nrm == 0) || (nrm < longint'(angle_limit));
        if (is_small) begin
            for (int i = 0; i < 3; i++) u[i] = v[i] <<< (OFRAC - IFRAC);
            rr[0][0] = one;   rr[0][1] = -u[2]; rr[0][2] = u[1];
            rr[1][0] = u[2];  rr[1][1] = one;   rr[1][2] = -u[0];
            rr[2][0] = -u[1]; rr[2][1] = u[0];  rr[2][2] = one;
        end else begin
            for (int i = 0; i < 3; i++) begin
                q = longint'((mag[i] << 30) / longint'(nrm));
                u[i] = v[i] < 0 ? -q : q;
            end
            kk[0][0] = 0;     kk[0][1] = -u[2]; kk[0][2] = u[1];
            kk[1][0] = u[2];  kk[1][1] = 0;     kk[1][2] = -u[0];
            kk[2][0] = -u[1]; kk[2][1] = u[0];  kk[2][2] = 0;
            angle_sin_cos(nrm <<< (30 - IFRAC), s, c);
            omc = (longint'(1) << 30) - c;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    aa[i][j] = rnd_shift(omc * kk[i][j], 30) + (i == j ? s : 0);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) acc += aa[i][k] * kk[k][j];
                    rr[i][j] = rnd_shift(acc, 60 - OFRAC) + (i == j ? one : 0);
                end
        end
        res.small_ang = is_small;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                res.mat[16*(3*i+j) +: 16] = 16'(clamp_one(rr[i][j]));
    endtask

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        rot_result_t exp_r;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rotation_of(s_tdata, exp_r);
                expected_mats.push_back(exp_r);
                void'(pending_vecs.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the pending transaction
            end else if (hold_input || pending_vecs.size() == 0
                         || (s_tvalid && s_tready && pending_vecs.size() == 0)) begin
                s_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_vecs[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor and output stall pattern
    always @(posedge aclk) begin
        rot_result_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_mats.size() == 0) begin
                    $display("%0t: unexpected matrix %h flag %b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    exp_r = expected_mats.pop_front();
                    n_matrices++;
                    if (exp_r.small_ang) n_small++;
                    for (int e = 0; e < 9; e++)
                        if (m_tdata[16*e +: 16] !== exp_r.mat[16*e +: 16]) begin
                            $display("%0t: entry r%0d%0d expected %0d actual %0d", $time,
                                     e / 3, e % 3, $signed(exp_r.mat[16*e +: 16]),
                                     $signed(m_tdata[16*e +: 16]));
                            errors++;
                        end
                    if (m_tuser !== exp_r.small_ang) begin
                        $display("%0t: small_angle_used expected %b actual %b", $time,
                                 exp_r.small_ang, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= stall_free ? 1'b1 : (($time / 70) % 3 != 0) || $urandom_range(0, 1);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [47:0] pack_vec(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 40)) - 20);
            2: return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($signed($urandom_range(0, 16000)) - 8000);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_vecs.size() != 0 || s_tvalid || expected_mats.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        angle_limit = val;
    endtask

    task automatic random_phase(input int count);
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 3);
            pending_vecs.push_back({rand_comp(mode), rand_comp(mode), rand_comp(mode)});
        end
    endtask

    initial begin
        logic [LIMIT_WIDTH-1:0] limits[5];
        limits = '{15'd0, 15'd32767, 15'd20, 15'd500, 15'd3000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed vectors at the reset limit
        pending_vecs.push_back(pack_vec(0, 0, 0));
        pending_vecs.push_back(pack_vec(32767, 0, 0));
        pending_vecs.push_back(pack_vec(-32768, 0, 0));
        pending_vecs.push_back(pack_vec(0, 32767, 0));
        pending_vecs.push_back(pack_vec(0, 0, -32768));
        pending_vecs.push_back(pack_vec(32767, 32767, 32767));
        pending_vecs.push_back(pack_vec(-32768, -32768, -32768));
        pending_vecs.push_back(pack_vec(1, 0, 0));
        pending_vecs.push_back(pack_vec(0, -1, 1));
        pending_vecs.push_back(pack_vec(25736, 0, 0));
        pending_vecs.push_back(pack_vec(0, 12868, 0));
        pending_vecs.push_back(pack_vec(0, 0, 51472));
        pending_vecs.push_back(pack_vec(-25736, 100, -7));
        pending_vecs.push_back(pack_vec(21845, -21846, 1));
        wait_drained();

        // zero limit still sends zero norm down the small path
        write_limit(15'd0);
        pending_vecs.push_back(pack_vec(0, 0, 0));
        pending_vecs.push_back(pack_vec(1, 1, 1));
        wait_drained();
        write_limit(15'd32767);
        pending_vecs.push_back(pack_vec(32767, -32768, 5));
        pending_vecs.push_back(pack_vec(20000, 20000, 10000));
        pending_vecs.push_back(pack_vec(-1, 0, 0));
        wait_drained();

        // random phases over several limits
        for (int p = 0; p < 5; p++) begin
            write_limit(limits[p]);
            stall_free = (p == 2);
            random_phase(N_RANDOM / 5);
            if (p == 3) begin
                // hold off the sender until the pipeline is empty
                while (pending_vecs.size() > N_RANDOM / 10) @(posedge aclk);
                hold_input = 1'b1;
                while (s_tvalid || expected_mats.size() != 0) @(posedge aclk);
                hold_input = 1'b0;
            end
            wait_drained();
        end

        $display("checked %0d matrices, %0d on the small-angle path, limit swept 0..32767",
                 n_matrices, n_small);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: axis_angle_to_rotation_matrix.f
hw/rtl/a2rm_pkg.sv
hw/rtl/a2rm_sqrt_cell.sv
hw/rtl/a2rm_step_cell.sv
hw/rtl/a2rm_matrix.sv
hw/rtl/axis_angle_to_rotation_matrix.sv
tb/sv/testbench.sv
